// ----- hdl/tcfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcfe_pkg;

   // field widths
   localparam int CMD_W    = 2;
   localparam int LDADDR_W = 16;
   localparam int BYTE_W   = 8;
   localparam int STAT_W   = 3;
   localparam int PC_W     = 56;
   localparam int OPC_W    = 4;
   localparam int REGF_W   = 4;
   localparam int WORD_W   = 64;

   // byte lanes of one instruction or data word
   localparam int LANES = 8;

   // instruction word layout
   localparam int OPC_LSB = 60;
   localparam int REG_LSB = 56;

   // commands
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   // opcodes
   localparam logic [OPC_W-1:0] OP_MOV  = 4'h1;
   localparam logic [OPC_W-1:0] OP_ADD  = 4'h2;
   localparam logic [OPC_W-1:0] OP_SUB  = 4'h3;
   localparam logic [OPC_W-1:0] OP_LOAD = 4'h4;
   localparam logic [OPC_W-1:0] OP_ST   = 4'h5;
   localparam logic [OPC_W-1:0] OP_JMP  = 4'h6;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STAT_W-1:0] STAT_HALTED      = 3'd1;
   localparam logic [STAT_W-1:0] STAT_PC_RANGE    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_OPCODE  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_REG     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_LOAD_RANGE  = 3'd5;
   localparam logic [STAT_W-1:0] STAT_STORE_RANGE = 3'd6;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_POST
   } state_type;

   // one result item
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PC_W-1:0]   next_pc;
      logic              is_running;
      logic [OPC_W-1:0]  executed_opcode;
      logic [REGF_W-1:0] target_register;
      logic [WORD_W-1:0] register_value;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/tcfe_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tcfe_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcfe_pkg::CMD_W-1:0]    command;
   logic [tcfe_pkg::LDADDR_W-1:0] load_address;
   logic [tcfe_pkg::BYTE_W-1:0]   load_byte;

   modport source (output valid, command, load_address, load_byte, input ready);
   modport sink   (input valid, command, load_address, load_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcfe_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tcfe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcfe_pkg::STAT_W-1:0] status;
   logic [tcfe_pkg::PC_W-1:0]   next_pc;
   logic                        is_running;
   logic [tcfe_pkg::OPC_W-1:0]  executed_opcode;
   logic [tcfe_pkg::REGF_W-1:0] target_register;
   logic [tcfe_pkg::WORD_W-1:0] register_value;

   modport source (output valid, status, next_pc, is_running, executed_opcode,
                   target_register, register_value, input ready);
   modport sink   (input valid, status, next_pc, is_running, executed_opcode,
                   target_register, register_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcfe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/toy_cpu_fetch_execute.sv -----
`timescale 1ns / 1ps
`default_nettype none

// step with a fetch: the result passes fetch read, register read, execute and staging (FETCH, EXEC, POST)
// byte write, start, no-op and unfetched step items: from accept straight to POST staging; one item in flight
// no new item is taken until the last has left POST; a step uses the eight-bank byte
// memory read port twice (fetch, then load data) and the single-port register file ram
// reset: pc 0, core running, registers read as zero; the byte memory is zeroed by a
// clearing pass over every row of the eight banks, during which no item is accepted
module toy_cpu_fetch_execute #(
   parameter int MEM_BYTES = 65536,
   parameter int NUM_REGS  = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   tcfe_req_if.sink  req,
   tcfe_rsp_if.source rsp
);

   localparam int ROWS   = (MEM_BYTES + 7) / 8;
   localparam int ROW_AW = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int REG_AW = NUM_REGS > 1 ? $clog2(NUM_REGS) : 1;
   localparam int LANES  = tcfe_pkg::LANES;
   localparam int PC_W   = tcfe_pkg::PC_W;
   localparam int WORD_W = tcfe_pkg::WORD_W;

   localparam logic [PC_W-1:0]   SPAN_MAX  = PC_W'(MEM_BYTES - 8);
   localparam logic [PC_W-1:0]   MEM_SIZE  = PC_W'(MEM_BYTES);
   localparam logic [4:0]        REG_COUNT = 5'(NUM_REGS);
   localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);
   localparam logic [PC_W-1:0]   PC_INC    = PC_W'(LANES);

   // row of bank b holding one byte of the word at address a
   function automatic logic [ROW_AW-1:0] bank_row(input logic [PC_W-1:0] a,
                                                  input logic [2:0] b);
      return a[ROW_AW+2:3] + ROW_AW'(b < a[2:0]);
   endfunction

   // control and architectural state
   tcfe_pkg::state_type state_ff, state_in;
   logic [ROW_AW-1:0]   clr_row_ff, clr_row_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic                run_ff, run_in;
   logic [NUM_REGS-1:0] reg_valid_ff, reg_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [WORD_W-1:0]      word_ff, word_in;
   logic                   rf_vld_rd_ff, rf_vld_rd_in;
   tcfe_pkg::result_type   res_ff, res_in;
   tcfe_pkg::result_type   out_ff, out_in;

   // memory ports
   logic [ROW_AW-1:0] bank_addr  [LANES];
   logic [7:0]        bank_wdata [LANES];
   logic [7:0]        bank_rdata [LANES];
   logic [LANES-1:0]  bank_we;
   logic              bank_re;
   logic [REG_AW-1:0] rf_addr;
   logic              rf_we;
   logic              rf_re;
   logic [WORD_W-1:0] rf_wdata;
   logic [WORD_W-1:0] rf_rdata;

   logic              accept;
   logic              out_free;
   logic              step_fetch;
   logic [2:0]        rd_lo;
   logic [WORD_W-1:0] rd_word;

   assign accept     = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign step_fetch = req.command == tcfe_pkg::CMD_STEP && run_ff && pc_ff <= SPAN_MAX;

   // eight byte banks, lane = address bits 2..0
   for (genvar g = 0; g < LANES; g++) begin : g_bank
      tcfe_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .rd_en   (bank_re),
         .addr    (bank_addr[g]),
         .wr_data (bank_wdata[g]),
         .rd_data (bank_rdata[g])
      );
   end

   // register file
   tcfe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .wr_en   (rf_we),
      .rd_en   (rf_re),
      .addr    (rf_addr),
      .wr_data (rf_wdata),
      .rd_data (rf_rdata)
   );

   // gather a little-endian word from the banks
   assign rd_lo = (state_ff == tcfe_pkg::ST_EXEC) ? word_ff[2:0] : pc_ff[2:0];
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rd_word[8*k +: 8] = bank_rdata[3'(rd_lo + 3'(k))];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcfe_pkg::ST_CLEAR: begin
            if (clr_row_ff == LAST_ROW) begin
               state_in = tcfe_pkg::ST_IDLE;
            end
         end
         tcfe_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = step_fetch ? tcfe_pkg::ST_FETCH : tcfe_pkg::ST_POST;
            end
         end
         tcfe_pkg::ST_FETCH: state_in = tcfe_pkg::ST_EXEC;
         tcfe_pkg::ST_EXEC:  state_in = tcfe_pkg::ST_POST;
         tcfe_pkg::ST_POST: begin
            if (out_free) begin
               state_in = tcfe_pkg::ST_IDLE;
            end
         end
         default: state_in = tcfe_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [PC_W-1:0]               a56;
      logic [tcfe_pkg::OPC_W-1:0]    opc;
      logic [tcfe_pkg::REGF_W-1:0]   rfld;
      logic [PC_W-1:0]               opnd;
      logic                          reg_ok;
      logic [WORD_W-1:0]             old_val;
      logic [WORD_W-1:0]             new_val;
      logic                          wr;
      logic [tcfe_pkg::STAT_W-1:0]   stat;
      logic [2:0]                    lane_k;

      a56     = PC_W'(req.load_address);
      opc     = word_ff[tcfe_pkg::OPC_LSB +: tcfe_pkg::OPC_W];
      rfld    = word_ff[tcfe_pkg::REG_LSB +: tcfe_pkg::REGF_W];
      opnd    = word_ff[PC_W-1:0];
      reg_ok  = {1'b0, rfld} < REG_COUNT;
      old_val = rf_vld_rd_ff ? rf_rdata : '0;
      new_val = old_val;
      wr      = 1'b0;
      stat    = tcfe_pkg::STAT_OK;
      lane_k  = '0;

      for (int b = 0; b < LANES; b++) begin
         bank_addr[b]  = '0;
         bank_wdata[b] = '0;
      end
      bank_we      = '0;
      bank_re      = 1'b0;
      rf_re        = 1'b0;
      rf_we        = 1'b0;
      rf_addr      = word_ff[tcfe_pkg::REG_LSB +: REG_AW];
      rf_wdata     = new_val;

      clr_row_in   = clr_row_ff;
      pc_in        = pc_ff;
      run_in       = run_ff;
      reg_valid_in = reg_valid_ff;
      word_in      = word_ff;
      rf_vld_rd_in = rf_vld_rd_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         // zero one row of every bank per cycle
         tcfe_pkg::ST_CLEAR: begin
            for (int b = 0; b < LANES; b++) begin
               bank_addr[b] = clr_row_ff;
            end
            bank_we    = '1;
            clr_row_in = clr_row_ff + ROW_AW'(1);
         end

         // take an item; everything but a step that fetches (running, pc in range) finishes here
         tcfe_pkg::ST_IDLE: begin
            if (accept) begin
               res_in.status          = tcfe_pkg::STAT_OK;
               res_in.next_pc         = pc_ff;
               res_in.is_running      = run_ff;
               res_in.executed_opcode = '0;
               res_in.target_register = '0;
               res_in.register_value  = '0;
               case (req.command)
                  tcfe_pkg::CMD_WRITE: begin
                     if (a56 < MEM_SIZE) begin
                        bank_addr[a56[2:0]]  = a56[ROW_AW+2:3];
                        bank_wdata[a56[2:0]] = req.load_byte;
                        bank_we[a56[2:0]]    = 1'b1;
                     end else begin
                        res_in.status = tcfe_pkg::STAT_STORE_RANGE;
                     end
                  end
                  tcfe_pkg::CMD_START: begin
                     pc_in             = a56;
                     run_in            = 1'b1;
                     res_in.next_pc    = a56;
                     res_in.is_running = 1'b1;
                  end
                  tcfe_pkg::CMD_STEP: begin
                     if (!run_ff) begin
                        res_in.status = tcfe_pkg::STAT_HALTED;
                     end else if (pc_ff > SPAN_MAX) begin
                        run_in            = 1'b0;
                        res_in.is_running = 1'b0;
                        res_in.status     = tcfe_pkg::STAT_PC_RANGE;
                     end else begin
                        bank_re = 1'b1;
                        for (int b = 0; b < LANES; b++) begin
                           bank_addr[b] = bank_row(pc_ff, 3'(b));
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // instruction word arrives: advance pc, read register and load data
         tcfe_pkg::ST_FETCH: begin
            word_in = rd_word;
            pc_in   = pc_ff + PC_INC;
            rf_re   = 1'b1;
            rf_addr = rd_word[tcfe_pkg::REG_LSB +: REG_AW];
            if ({1'b0, rd_word[tcfe_pkg::REG_LSB +: tcfe_pkg::REGF_W]} < REG_COUNT) begin
               rf_vld_rd_in = reg_valid_ff[rd_word[tcfe_pkg::REG_LSB +: REG_AW]];
            end else begin
               rf_vld_rd_in = 1'b0;
            end
            bank_re = 1'b1;
            for (int b = 0; b < LANES; b++) begin
               bank_addr[b] = bank_row(rd_word[PC_W-1:0], 3'(b));
            end
         end

         // execute and write back
         tcfe_pkg::ST_EXEC: begin
            if (opc inside {[tcfe_pkg::OP_MOV:tcfe_pkg::OP_ST]} && !reg_ok) begin
               stat = tcfe_pkg::STAT_BAD_REG;
            end else begin
               case (opc)
                  tcfe_pkg::OP_MOV: begin
                     new_val = WORD_W'(opnd);
                     wr      = 1'b1;
                  end
                  tcfe_pkg::OP_ADD: begin
                     new_val = old_val + WORD_W'(opnd);
                     wr      = 1'b1;
                  end
                  tcfe_pkg::OP_SUB: begin
                     new_val = old_val - WORD_W'(opnd);
                     wr      = 1'b1;
                  end
                  tcfe_pkg::OP_LOAD: begin
                     wr = 1'b1;
                     if (opnd <= SPAN_MAX) begin
                        new_val = rd_word;
                     end else begin
                        new_val = '0;
                        stat    = tcfe_pkg::STAT_LOAD_RANGE;
                     end
                  end
                  tcfe_pkg::OP_ST: begin
                     if (opnd <= SPAN_MAX) begin
                        bank_we = '1;
                        for (int b = 0; b < LANES; b++) begin
                           lane_k        = 3'(b) - opnd[2:0];
                           bank_addr[b]  = bank_row(opnd, 3'(b));
                           bank_wdata[b] = old_val[8*lane_k +: 8];
                        end
                     end else begin
                        stat = tcfe_pkg::STAT_STORE_RANGE;
                     end
                  end
                  tcfe_pkg::OP_JMP: begin
                     pc_in = opnd;
                  end
                  default: begin
                     run_in = 1'b0;
                     stat   = tcfe_pkg::STAT_BAD_OPCODE;
                  end
               endcase
            end
            rf_we    = wr;
            rf_wdata = new_val;
            if (wr) begin
               reg_valid_in[rfld[REG_AW-1:0]] = 1'b1;
            end
            res_in.status          = stat;
            res_in.next_pc         = pc_in;
            res_in.is_running      = run_in;
            res_in.executed_opcode = opc;
            res_in.target_register = rfld;
            res_in.register_value  = reg_ok ? new_val : '0;
         end

         // hand the result to the output register
         tcfe_pkg::ST_POST: begin
            if (out_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end

         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcfe_pkg::ST_CLEAR;
         clr_row_ff   <= '0;
         pc_ff        <= '0;
         run_ff       <= 1'b1;
         reg_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         pc_ff        <= pc_in;
         run_ff       <= run_in;
         reg_valid_ff <= reg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      rf_vld_rd_ff <= rf_vld_rd_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   // channel outputs
   assign req.ready           = state_ff == tcfe_pkg::ST_IDLE;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = out_ff.status;
   assign rsp.next_pc         = out_ff.next_pc;
   assign rsp.is_running      = out_ff.is_running;
   assign rsp.executed_opcode = out_ff.executed_opcode;
   assign rsp.target_register = out_ff.target_register;
   assign rsp.register_value  = out_ff.register_value;

`ifndef SYNTHESIS
   a_step_fetches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcfe_pkg::ST_IDLE && accept && step_fetch)
         |=> state_ff == tcfe_pkg::ST_FETCH)
      else $error("step with pc in range did not start a fetch");

   a_pc_advance: assert property (@(posedge clock) disable iff (reset)
      state_ff == tcfe_pkg::ST_FETCH |=> pc_ff == $past(pc_ff) + PC_INC)
      else $error("pc did not advance by one word after fetch");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcfe_pkg::ST_CLEAR && clr_row_ff == LAST_ROW)
         |=> state_ff == tcfe_pkg::ST_IDLE)
      else $error("clearing pass did not end at the last row");

   a_halt_source: assert property (@(posedge clock) disable iff (reset)
      $fell(run_ff) |-> ($past(state_ff) == tcfe_pkg::ST_IDLE ||
                         $past(state_ff) == tcfe_pkg::ST_EXEC))
      else $error("running flag cleared outside accept or execute");
`endif

endmodule

`default_nettype wire
